@@ rtl/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned CODE_W  = 21;
  localparam int unsigned QDEPTH  = 4;   // result queue entries
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CODE_W-1:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [CODE_W-1:0] CP_LIMIT     = 21'h110000;
  localparam logic [5:0]        HI_SURR_TAG  = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]        LO_SURR_TAG  = 6'b110111;  // 0xDC00 >> 10

  // One queued result beat
  typedef struct packed {
    logic              last;
    logic [UNIT_W-1:0] unit;
  } u8u16_beat_t;

  // Results produced by one input byte: up to two units
  typedef struct packed {
    logic        vld0;
    logic        vld1;
    u8u16_beat_t beat0;
    u8u16_beat_t beat1;
  } u8u16_emit_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic              ready;
    logic [QCNT_W-1:0] count;
  } u8u16_qstat_t;

endpackage

`default_nettype wire

@@ rtl/utf8_to_utf16_transcoder_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit: UTF-8 byte stream in, UTF-16 code units out.
// First unit beat: valid in the cycle after its byte beat, on an idle output.
// Throughput: one byte per cycle while the queue has room for a pair; the
// queue gives one unit beat at a time, so a surrogate pair leaves as two beats.
// Reset: synchronous active-low rst_n clears sequence state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] out_unit
  output logic             out_tlast   // run_last: final unit of this byte
);
  import u8u16_pkg::*;

  u8u16_emit_t  emit;
  u8u16_beat_t  head;
  u8u16_qstat_t qstat;
  logic         in_acc;

  // A byte beat is taken whenever the queue has room for a full pair
  assign in_tready = qstat.ready;
  assign in_acc    = in_tvalid && in_tready;

  // Lead/continuation tracking and unit generation, all in one pass
  u8u16_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_en  (in_acc),
    .byte_in (in_tdata),
    .emit    (emit)
  );

  // Result register: queue decouples output stalls from input acceptance
  u8u16_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (in_acc),
    .emit     (emit),
    .pop_vld  (out_tvalid),
    .pop_rdy  (out_tready),
    .pop_beat (head),
    .stat     (qstat)
  );

  assign out_tdata = head.unit;
  assign out_tlast = head.last;

`ifndef SYNTHESIS
  // Fill level never passes the queue depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // A zero byte always yields a unit beat next cycle
  a_zero_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tdata == 8'h00) |=> out_tvalid)
    else $error("zero byte gave no unit");

  // A bad lead byte into an empty queue yields nothing
  a_bad_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tdata[7:3] == 5'b11111 && qstat.count == '0) |=> !out_tvalid)
    else $error("bad lead byte produced output");

  // Output beats only when the queue holds something
  a_vld_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (qstat.count == '0) |-> !out_tvalid)
    else $error("output valid with empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/u8u16_decode.sv @@
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence tracker and code point to UTF-16 unit conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          acc_en,
  input  wire logic [u8u16_pkg::BYTE_W-1:0]  byte_in,
  output u8u16_pkg::u8u16_emit_t             emit
);
  import u8u16_pkg::*;

  logic [1:0]        bytes_left_r, bytes_left_nxt;
  logic [CODE_W-1:0] code_accum_r, code_accum_nxt;
  logic              is_cont;
  logic              done;
  logic [CODE_W-1:0] cp;
  logic [CODE_W-1:0] v;

  assign is_cont = (byte_in[7:6] == 2'b10);

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    code_accum_nxt = code_accum_r;
    done           = 1'b0;
    cp             = code_accum_r;
    if ((bytes_left_r != 2'd0) && is_cont) begin
      code_accum_nxt = {code_accum_r[CODE_W-7:0], byte_in[5:0]};
      bytes_left_nxt = bytes_left_r - 2'd1;
      done           = (bytes_left_r == 2'd1);
      cp             = code_accum_nxt;
    end else begin
      bytes_left_nxt = 2'd0;
      priority casez (byte_in)
        8'b0???????: begin
          code_accum_nxt = {{(CODE_W-BYTE_W){1'b0}}, byte_in};
          done           = 1'b1;
          cp             = code_accum_nxt;
        end
        8'b10??????: ; // stray continuation
        8'b110?????: begin
          code_accum_nxt = {{(CODE_W-5){1'b0}}, byte_in[4:0]};
          bytes_left_nxt = 2'd1;
        end
        8'b1110????: begin
          code_accum_nxt = {{(CODE_W-4){1'b0}}, byte_in[3:0]};
          bytes_left_nxt = 2'd2;
        end
        8'b11110???: begin
          code_accum_nxt = {{(CODE_W-3){1'b0}}, byte_in[2:0]};
          bytes_left_nxt = 2'd3;
        end
        default: ; // bad lead byte, skipped
      endcase
    end
  end

  // Code point to units
  assign v = cp - CP_SUPP_BASE;

  always_comb begin
    emit = '0;
    if (done) begin
      if (cp < CP_SUPP_BASE) begin
        emit.vld0       = 1'b1;
        emit.beat0.unit = cp[UNIT_W-1:0];
        emit.beat0.last = 1'b1;
      end else if (cp < CP_LIMIT) begin
        emit.vld0       = 1'b1;
        emit.beat0.unit = {HI_SURR_TAG, v[19:10]};
        emit.beat0.last = 1'b0;
        emit.vld1       = 1'b1;
        emit.beat1.unit = {LO_SURR_TAG, v[9:0]};
        emit.beat1.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 2'd0;
      code_accum_r <= '0;
    end else if (acc_en) begin
      bytes_left_r <= bytes_left_nxt;
      code_accum_r <= code_accum_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/u8u16_outq.sv @@
// ----------------------------------------------------------------------------
// u8u16_outq
// Small result queue taking up to two beats per cycle, giving one while pop_rdy is high.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_outq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push_en,
  input  wire u8u16_pkg::u8u16_emit_t  emit,
  output logic                         pop_vld,
  input  wire logic                    pop_rdy,
  output u8u16_pkg::u8u16_beat_t       pop_beat,
  output u8u16_pkg::u8u16_qstat_t      stat
);
  import u8u16_pkg::*;

  localparam int unsigned DEPTH = QDEPTH;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u8u16_beat_t       mem_r [DEPTH];
  logic [IDX_W-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  wr_p1;
  logic              do_pop;
  logic              w0, w1;
  logic [1:0]        n_push;

  function automatic logic [IDX_W-1:0] inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(DEPTH - 1)) r = '0;
    else                        r = p + 1'b1;
    return r;
  endfunction

  assign do_pop   = pop_rdy && (cnt_r != '0);
  assign w0       = push_en && emit.vld0;
  assign w1       = push_en && emit.vld1;
  assign n_push   = {1'b0, w0} + {1'b0, w1};
  assign wr_p1    = inc(wr_r);

  assign pop_vld  = (cnt_r != '0);
  assign pop_beat = mem_r[rd_r];

  // Ready only from registered fill level: room for a full pair
  assign stat.ready = (cnt_r <= CNT_W'(DEPTH - 2));
  assign stat.count = QCNT_W'(cnt_r);

  always_comb begin
    wr_nxt  = wr_r;
    if (w1)      wr_nxt = inc(wr_p1);
    else if (w0) wr_nxt = wr_p1;
    rd_nxt  = do_pop ? inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(n_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (w0) mem_r[wr_r]  <= emit.beat0;
    if (w1) mem_r[wr_p1] <= emit.beat1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to UTF-16 transcoder. A directed run
// covers the byte extremes and the malformed-stream cases, then about 1100
// random bytes follow, mostly well-formed sequences with random payload and
// some truncated sequences and noise. Both stream sides idle at random, and
// the receiver once holds off long enough for the block to stall its input.
// A scoreboard decodes every accepted byte and checks each unit beat in order.
// ----------------------------------------------------------------------------

module tb_top;
  import u8u16_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1100;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 80;   // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 20;   // quiet time after last unit

  // Decodes the accepted byte stream and holds the units still due
  class utf16_scoreboard;
    bit [1:0]     seq_left;    // continuation bytes still awaited
    bit [20:0]    code_acc;    // code point bits gathered so far
    u8u16_beat_t  units_due[$];
    int unsigned  fail_count;

    function new();
      seq_left   = '0;
      code_acc   = '0;
      fail_count = 0;
    endfunction

    // One or two units for a finished code point, none above the range
    function void queue_code_point(bit [20:0] cp);
      u8u16_beat_t beat;
      bit [19:0]   offs;
      if (cp < CP_SUPP_BASE) begin
        beat.unit = cp[15:0];
        beat.last = 1'b1;
        units_due.push_back(beat);
      end else if (cp < CP_LIMIT) begin
        offs = 20'(cp - CP_SUPP_BASE);
        beat.unit = {HI_SURR_TAG, offs[19:10]};
        beat.last = 1'b0;
        units_due.push_back(beat);
        beat.unit = {LO_SURR_TAG, offs[9:0]};
        beat.last = 1'b1;
        units_due.push_back(beat);
      end
    endfunction

    function void note_byte(bit [7:0] b);
      bit cont;
      cont = (b[7:6] == 2'b10);
      if (seq_left != 0 && cont) begin
        code_acc = {code_acc[14:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 0)
          queue_code_point(code_acc);
        return;
      end
      // anything else abandons a pending sequence
      seq_left = '0;
      if (!b[7]) begin
        code_acc = {13'd0, b};
        queue_code_point(code_acc);
      end else if (b[7:5] == 3'b110) begin
        code_acc = {16'd0, b[4:0]};
        seq_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        code_acc = {17'd0, b[3:0]};
        seq_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        code_acc = {18'd0, b[2:0]};
        seq_left = 2'd3;
      end
      // stray continuation and F8..FF leads are dropped
    endfunction

    function void check_unit(bit [15:0] unit, bit last);
      u8u16_beat_t want;
      if (units_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected unit beat: unit=%04h last=%0b", unit, last);
        return;
      end
      want = units_due.pop_front();
      if (want.unit !== unit || want.last !== last) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unit mismatch: expected unit=%04h last=%0b, got unit=%04h last=%0b",
                   want.unit, want.last, unit, last);
      end
    endfunction

    function int unsigned pending();
      return units_due.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic       out_tlast;

  // idle modes, switched per phase by the stimulus process
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_req  = 1'b0;   // asks the receiver for one long hold-off

  utf16_scoreboard sb;

  utf8_to_utf16_transcoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [7:0] in_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [15:0] out_unit
    .out_tlast  (out_tlast)     // run_last
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Byte beats are noted before unit beats of the same edge, so even a result
  // given in the same cycle as its byte would find its expectation in place.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_byte(in_tdata);
      if (out_tvalid && out_tready)
        sb.check_unit(out_tdata, out_tlast);
    end
  end

  // Offer one byte after an optional gap; returns at the falling edge after
  // the beat. tvalid stays high into the next byte when there is no gap.
  task automatic send_byte(input bit [7:0] b);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  // Lead byte for a len-byte sequence, then keep-1 continuation bytes with
  // random payload; keep < len gives a truncated sequence.
  task automatic send_sequence(input int unsigned len, input int unsigned keep,
                               output int unsigned n);
    bit [7:0] lead;
    case (len)
      1:       lead = 8'($urandom_range(0, 127));
      2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
      3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
      default: lead = 8'hF0 | 8'($urandom_range(0, 7));
    endcase
    send_byte(lead);
    n = 1;
    while (n < keep) begin
      send_byte(8'h80 | 8'($urandom_range(0, 63)));
      n++;
    end
  endtask

  // Receiver: random stall before each beat, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end
      stall = recv_idle ? $urandom_range(0, 7) : 0;
      repeat (stall) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    bit [7:0]    directed[$];
    int unsigned sent, n, len, pick, chunk, k;
    sb = new();

    directed = '{
      8'h00,                        // zero terminator
      8'h7F,                        // largest ASCII
      8'hC2, 8'hA9,                 // two-byte form
      8'hE2, 8'h82, 8'hAC,          // three-byte form
      8'hF4, 8'h8F, 8'hBF, 8'hBF,   // top of the code space, surrogate pair
      8'hF7, 8'hBF, 8'hBF, 8'hBF,   // beyond the code space: no unit
      8'h80,                        // stray continuation
      8'hFF,                        // bad lead
      8'hE2, 8'h82, 8'h41,          // sequence cut short by ASCII
      8'hC3, 8'h00,                 // zero inside a sequence
      8'hC0, 8'h80,                 // overlong NUL, passed through
      8'hED, 8'hA0, 8'h80           // lone surrogate code point
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_byte(directed[i]);

    // Random phase: chunks with differing idle modes; one chunk runs flat out
    // against a long receiver hold-off so the result queue fills up.
    sent  = 0;
    chunk = 0;
    while (sent < RANDOM_BYTES) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if (chunk == 6) begin
        send_idle = 1'b0;
        hold_req  = 1'b1;
      end
      for (k = 0; k < 15; k++) begin
        pick = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        if (pick < 80) begin
          send_sequence(len, len, n);
          sent += n;
        end else if (pick < 92) begin
          len = $urandom_range(2, 4);
          send_sequence(len, $urandom_range(1, len - 1), n);
          sent += n;
        end else begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
      end
      chunk++;
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
